// ===== hw/rtl/slt_pkg.sv =====
// Shared types and constants for the sorted list table unit.
// No dependencies; imported by every module of the block.
package slt_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int OPCODE_W       = 3;
    localparam int STATUS_W       = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_READ   = 3'd3,
        OP_REWIND = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic execute;   // run the latched request against the table
    } cmd_t;

endpackage

// ===== hw/rtl/slt_ctrl.sv =====
// Request sequencer for the sorted list table: accept, execute, respond.
// Depends on slt_pkg.
module slt_ctrl
    import slt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                // a new request may enter the same cycle the result leaves
                if (m_tready) state_next = s_tvalid ? S_EXEC : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
            end
            S_RESP: begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.capture = s_tready & s_tvalid;
    end

endmodule

// ===== hw/rtl/slt_dpath.sv =====
// Table storage, per-entry compare cells, shift network and result registers.
// Depends on slt_pkg; driven by slt_ctrl through cmd_t.
module slt_dpath
    import slt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    input  logic [OPCODE_W-1:0]   req_opcode,
    input  logic [DATA_WIDTH-1:0] req_value,
    output logic [STATUS_W-1:0]   rsp_status,
    output logic [DATA_WIDTH-1:0] rsp_item,
    output logic [CNT_W-1:0]      rsp_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [OPCODE_W-1:0]   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] entries_reg [CAPACITY];
    logic [DATA_WIDTH-1:0] entries_next [CAPACITY];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rpos_reg, rpos_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] item_reg, item_next;

    logic [CAPACITY-1:0] lt_vec;   // entry is held and below the operand
    logic [CAPACITY-1:0] eq_vec;   // entry is held and equals the operand
    logic                found;
    logic                full;
    logic                ins_en;
    logic                del_en;

    // one compare cell per slot; the table is sorted, so lt_vec is a prefix
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic held;
        assign held      = CNT_W'(i) < count_reg;
        assign lt_vec[i] = held && ($signed(entries_reg[i]) < $signed(val_reg));
        assign eq_vec[i] = held && (entries_reg[i] == val_reg);

        always_comb begin
            entries_next[i] = entries_reg[i];
            if (ins_en && !lt_vec[i]) begin
                if (i == 0) begin
                    entries_next[i] = val_reg;
                end else begin
                    entries_next[i] = lt_vec[(i > 0) ? i - 1 : 0] ? val_reg
                                    : entries_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (del_en && !lt_vec[i] && (i < CAPACITY - 1)) begin
                // slots from the first match upward close the gap
                entries_next[i] = entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge aclk) begin
            entries_reg[i] <= entries_next[i];
        end
    end

    assign found = |eq_vec;
    assign full  = (count_reg == FULL_CNT);

    always_comb begin
        ins_en      = 1'b0;
        del_en      = 1'b0;
        count_next  = count_reg;
        rpos_next   = rpos_reg;
        status_next = status_reg;
        item_next   = item_reg;
        if (cmd.execute) begin
            status_next = ST_OK;
            item_next   = '0;
            case (op_t'(op_reg))
                OP_INSERT: begin
                    rpos_next = '0;
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        ins_en     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DELETE: begin
                    rpos_next = '0;
                    if (found) begin
                        del_en     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end else begin
                        status_next = ST_MISS;
                    end
                end
                OP_LOOKUP: begin
                    if (found) begin
                        item_next = val_reg;
                    end else begin
                        status_next = ST_MISS;
                    end
                end
                OP_READ: begin
                    if (rpos_reg < count_reg) begin
                        item_next = entries_reg[rpos_reg[IDX_W-1:0]];
                        rpos_next = rpos_reg + 1'b1;
                    end else begin
                        status_next = ST_MISS;
                    end
                end
                OP_REWIND: begin
                    rpos_next = '0;
                end
                OP_CLEAR: begin
                    count_next = '0;
                    rpos_next  = '0;
                end
                default: begin
                    status_next = ST_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= req_opcode;
            val_reg <= req_value;
        end
        status_reg <= status_next;
        item_reg   <= item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rpos_reg  <= '0;
        end else begin
            count_reg <= count_next;
            rpos_reg  <= rpos_next;
        end
    end

    assign rsp_status = status_reg;
    assign rsp_item   = item_reg;
    assign rsp_count  = count_reg;

endmodule

// ===== hw/rtl/sorted_list_table_unit.sv =====
// Sorted list table unit: a bounded table of signed values kept ascending.
// Channels: s_ (requests: opcode and value) and m_ (results: status, item, count),
// both valid/ready streams; one result for every request.
// Opcodes: insert in order, delete first match, lookup, read next at the
// cursor, rewind cursor, clear. Insert and delete rewind the cursor.
// Sequence: an accepted request is latched, then run in the execute state, in
// which every slot compares and shifts in parallel, and its result is loaded
// into the result register and presented in the respond state. Requests do
// not overlap; a new request may be taken in the same cycle the previous
// result is taken.
// Stall: while m_tready is low the result is held and s_tready stays low.
// Reset (aresetn low, synchronous): count and cursor go to zero, no result
// is pending; slot contents are not cleared since unused slots are never read.
// Depends on slt_pkg, slt_ctrl, slt_dpath.
module sorted_list_table_unit
    import slt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int CNT_W      = $clog2(CAPACITY + 1),
    parameter int IN_W       = OPCODE_W + DATA_WIDTH,
    parameter int OUT_W      = STATUS_W + DATA_WIDTH + CNT_W,
    parameter int IN_BYTES   = (IN_W + 7) / 8,
    parameter int OUT_BYTES  = (OUT_W + 7) / 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_BYTES*8-1:0]  s_tdata,   // opcode, value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata    // status, item_out, count
);

    cmd_t                  cmd;
    logic [STATUS_W-1:0]   rsp_status;
    logic [DATA_WIDTH-1:0] rsp_item;
    logic [CNT_W-1:0]      rsp_count;

    slt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    slt_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req_opcode (s_tdata[OPCODE_W-1:0]),
        .req_value  (s_tdata[OPCODE_W +: DATA_WIDTH]),
        .rsp_status (rsp_status),
        .rsp_item   (rsp_item),
        .rsp_count  (rsp_count)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[OUT_W-1:0] = {rsp_count, rsp_item, rsp_status};
    end

endmodule

// ===== hw/rtl/slt_checker.sv =====
// Port-level checks for sorted_list_table_unit, attached by bind.
// Depends on slt_pkg and on the top level's port list.
module slt_checker
    import slt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int CNT_W      = $clog2(CAPACITY + 1),
    parameter int IN_W       = OPCODE_W + DATA_WIDTH,
    parameter int OUT_W      = STATUS_W + DATA_WIDTH + CNT_W,
    parameter int IN_BYTES   = (IN_W + 7) / 8,
    parameter int OUT_BYTES  = (OUT_W + 7) / 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_BYTES*8-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_BYTES*8-1:0] m_tdata
);

    localparam int CNT_LSB = STATUS_W + DATA_WIDTH;

    logic [STATUS_W-1:0] out_status;
    logic [CNT_W-1:0]    out_count;
    logic                req_acc;

    assign out_status = m_tdata[STATUS_W-1:0];
    assign out_count  = m_tdata[CNT_LSB +: CNT_W];
    assign req_acc    = s_tvalid && s_tready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        req_acc |=> !m_tvalid ##1 m_tvalid)
        else $error("result not presented two cycles after request");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == ST_FULL |-> out_count == CNT_W'(CAPACITY))
        else $error("full status with table not full");

endmodule

bind sorted_list_table_unit slt_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_slt_checker (.*);
